FILE: hw/rtl/lrhs_pkg.sv
package lrhs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ROT_BITS  = 30;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_POINT = 2'd0;
  localparam func_t FUNC_FRAME = 2'd1;
  localparam func_t FUNC_ODOM  = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SELF_RADIUS_SQ   = 3'd0;
  localparam reg_idx_t REG_NEAR_MIN_SQ      = 3'd1;
  localparam reg_idx_t REG_NEAR_MAX_SQ      = 3'd2;
  localparam reg_idx_t REG_FAR_MIN_SQ       = 3'd3;
  localparam reg_idx_t REG_FAR_MAX_SQ       = 3'd4;
  localparam reg_idx_t REG_GROUND_FLOOR     = 3'd5;
  localparam reg_idx_t REG_MAX_HEIGHT       = 3'd6;
  localparam reg_idx_t REG_MODE_FLAGS       = 3'd7;

  // mode flag bit positions
  localparam int MODE_FILTER_ON  = 0;
  localparam int MODE_HEIGHT_CMP = 1;
  localparam int MODE_GROUND_EN  = 2;
  localparam int MODE_NEED_ODOM  = 3;

  localparam logic BAND_NEAR = 1'b0;
  localparam logic BAND_FAR  = 1'b1;

  localparam logic signed [31:0] ROT_ONE = 32'sh4000_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic               point_valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        intensity;
    logic signed [31:0] rot_zx;
    logic signed [31:0] rot_zy;
    logic signed [31:0] rot_zz;
    logic signed [31:0] trans_z;
    logic signed [31:0] odom_height;
  } in_t;

  typedef struct packed {
    logic               band;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_intensity;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic [31:0]        self_radius_sq;
    logic [31:0]        near_min_sq;
    logic [31:0]        near_max_sq;
    logic [31:0]        far_min_sq;
    logic [31:0]        far_max_sq;
    logic signed [31:0] ground_floor;
    logic signed [31:0] max_height;
    logic [3:0]         mode_flags;
  } cfg_t;

  // point as captured at entry, with the state it sees
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        intensity;
    logic               point_valid;
    logic               filter_on;
    logic               ground_en;
    logic signed [31:0] rot_zx;
    logic signed [31:0] rot_zy;
    logic signed [31:0] rot_zz;
    logic signed [31:0] woff;
    logic signed [32:0] dz;
  } pt_t;

  // checks and coordinates ready for the output stage
  typedef struct packed {
    logic               point_valid;
    logic               filter_on;
    logic               lt_self;
    logic               ge_far;
    logic               in_near;
    logic               in_far;
    logic               z_bad;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        intensity;
  } dec_t;

  typedef struct packed {
    logic b;
    logic c;
    logic d;
  } stage_en_t;

endpackage

FILE: hw/rtl/lrhs_arith.sv
module lrhs_arith (
  input  logic               clk,
  input  lrhs_pkg::stage_en_t en,
  input  lrhs_pkg::pt_t      a,
  input  lrhs_pkg::cfg_t     cfg,
  output lrhs_pkg::dec_t     d
);
  import lrhs_pkg::*;

  localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S32_MIN = -36'sd2147483648;
  localparam logic signed [64:0] HALF_ROT = 65'sd536870912;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // stage b: products
  logic signed [63:0] sqx_full, sqy_full;
  logic [62:0]        b_sqx, b_sqy;
  logic signed [63:0] b_zpx, b_zpy, b_zpz;
  logic signed [64:0] b_cpx, b_cpy, b_cpz;
  logic signed [31:0] b_px, b_py, b_pz, b_woff;
  logic signed [32:0] b_dz;
  logic [31:0]        b_int;
  logic               b_pv, b_fon, b_gen;

  assign sqx_full = 64'(a.px) * 64'(a.px);
  assign sqy_full = 64'(a.py) * 64'(a.py);

  always_ff @(posedge clk) begin
    if (en.b) begin
      b_sqx  <= sqx_full[62:0];
      b_sqy  <= sqy_full[62:0];
      b_zpx  <= 64'(a.px) * 64'(a.rot_zx);
      b_zpy  <= 64'(a.py) * 64'(a.rot_zy);
      b_zpz  <= 64'(a.pz) * 64'(a.rot_zz);
      b_cpx  <= 65'(a.dz) * 65'(a.rot_zx);
      b_cpy  <= 65'(a.dz) * 65'(a.rot_zy);
      b_cpz  <= 65'(a.dz) * 65'(a.rot_zz);
      b_px   <= a.px;
      b_py   <= a.py;
      b_pz   <= a.pz;
      b_woff <= a.woff;
      b_dz   <= a.dz;
      b_int  <= a.intensity;
      b_pv   <= a.point_valid;
      b_fon  <= a.filter_on;
      b_gen  <= a.ground_en;
    end
  end

  // stage c: radius, world z sum, rounded corrections
  logic [63:0]        r2_sum;
  logic signed [65:0] zsum;
  logic signed [64:0] tx, ty, tz;
  logic [47:0]        c_r2;
  logic signed [35:0] c_zfl;
  logic signed [35:0] c_cx, c_cy, c_cz;
  logic signed [31:0] c_px, c_py, c_pz, c_woff;
  logic signed [32:0] c_dz;
  logic [31:0]        c_int;
  logic               c_pv, c_fon, c_gen;

  always_comb begin
    r2_sum = {1'b0, b_sqx} + {1'b0, b_sqy};
    zsum   = 66'(b_zpx) + 66'(b_zpy) + 66'(b_zpz);
    tx     = b_cpx + HALF_ROT;
    ty     = b_cpy + HALF_ROT;
    tz     = b_cpz + HALF_ROT;
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      c_r2   <= r2_sum[63:FRAC_BITS];
      c_zfl  <= zsum[65:ROT_BITS];
      c_cx   <= 36'(b_px) - 36'($signed(tx[64:ROT_BITS]));
      c_cy   <= 36'(b_py) - 36'($signed(ty[64:ROT_BITS]));
      c_cz   <= 36'(b_pz) - 36'($signed(tz[64:ROT_BITS]));
      c_px   <= b_px;
      c_py   <= b_py;
      c_pz   <= b_pz;
      c_woff <= b_woff;
      c_dz   <= b_dz;
      c_int  <= b_int;
      c_pv   <= b_pv;
      c_fon  <= b_fon;
      c_gen  <= b_gen;
    end
  end

  // stage d: compensated z, band compares, saturation
  logic signed [37:0] zw;
  logic [47:0]        lim_self, lim_nmin, lim_nmax, lim_fmin, lim_fmax;

  always_comb begin
    zw       = 38'(c_zfl) + 38'(c_woff) - 38'(c_dz);
    lim_self = {16'd0, cfg.self_radius_sq};
    lim_nmin = {16'd0, cfg.near_min_sq};
    lim_nmax = {16'd0, cfg.near_max_sq};
    lim_fmin = {16'd0, cfg.far_min_sq};
    lim_fmax = {16'd0, cfg.far_max_sq};
  end

  always_ff @(posedge clk) begin
    if (en.d) begin
      d.point_valid <= c_pv;
      d.filter_on   <= c_fon;
      d.lt_self     <= c_r2 < lim_self;
      d.ge_far      <= c_r2 >= lim_fmax;
      d.in_near     <= (c_r2 >= lim_nmin) && (c_r2 < lim_nmax);
      d.in_far      <= (c_r2 >= lim_fmin) && (c_r2 < lim_fmax);
      d.z_bad       <= c_gen && ((zw < 38'(cfg.ground_floor)) ||
                                 (zw > 38'(cfg.max_height)));
      d.px          <= c_px;
      d.py          <= c_py;
      d.pz          <= c_pz;
      d.cx          <= sat32(c_cx);
      d.cy          <= sat32(c_cy);
      d.cz          <= sat32(c_cz);
      d.intensity   <= c_int;
    end
  end

endmodule

FILE: hw/rtl/lrhs_emit.sv
module lrhs_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            vd,
  input  lrhs_pkg::dec_t  d,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output lrhs_pkg::out_t  out_data
);
  import lrhs_pkg::*;

  logic keep;
  out_t word;
  logic o_dup;

  always_comb begin
    if (d.filter_on) begin
      keep = d.point_valid && !d.lt_self && !d.ge_far && !d.z_bad &&
             (d.in_near || d.in_far);
      word.band        = d.in_near ? BAND_NEAR : BAND_FAR;
      word.out_x       = d.cx;
      word.out_y       = d.cy;
      word.out_z       = d.cz;
      word.last_of_run = 1'b1;
    end else begin
      // pass-through: near copy first, far copy follows
      keep             = 1'b1;
      word.band        = BAND_NEAR;
      word.out_x       = d.px;
      word.out_y       = d.py;
      word.out_z       = d.pz;
      word.last_of_run = 1'b0;
    end
    word.out_intensity = d.intensity;
  end

  assign ready = !out_valid || (!out_stall && !o_dup);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      o_dup     <= 1'b0;
    end else if (ready) begin
      out_valid <= vd && keep;
      o_dup     <= vd && keep && !d.filter_on;
    end else if (!out_stall && o_dup) begin
      o_dup <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && vd && keep) begin
      out_data <= word;
    end else if (!ready && !out_stall && o_dup) begin
      out_data.band        <= BAND_FAR;
      out_data.last_of_run <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/lidar_range_height_split_filter.sv
// lidar range/height split filter
//
// input channel (in_valid/in_stall/in_data) carries points, frame loads and
// odometry heights; frame loads and odometry update the block state at the
// edge the word is accepted and cause no output. points flow through a
// five-register pipeline: entry capture, multipliers, wide adds, compares
// and saturation, output register. throughput is one point per cycle while
// the output is neither stalled nor sending a far copy; a point passed
// through with filtering off yields two output words, since the single
// output register sends the near copy and then the far copy.
// out_stall holds the output word; stages behind it keep filling bubbles
// and in_stall rises only when the entry stage cannot move.
// config writes (cfg_valid/cfg_ready/cfg_index/cfg_data) are always taken;
// cfg_ready is held high. rst (synchronous) loads the register defaults,
// clears odometry and frame state and empties the pipeline.
module lidar_range_height_split_filter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lrhs_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lrhs_pkg::out_t       out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  lrhs_pkg::reg_idx_t   cfg_index,
  input  logic [31:0]          cfg_data
);
  import lrhs_pkg::*;

  function automatic logic signed [31:0] clamp_rot(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > ROT_ONE) begin
      r = ROT_ONE;
    end else if (v < -ROT_ONE) begin
      r = -ROT_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  cfg_t cfg;

  logic               odom_seen;
  logic signed [31:0] ref_height, cur_height;
  logic signed [31:0] rot_zx, rot_zy, rot_zz;
  logic signed [31:0] world_offset_z;

  logic      va, vb, vc, vd;
  logic      rdy_a, rdy_b, rdy_c, rdy_d;
  logic      emit_ready;
  logic      in_take;
  logic      odom_ok;
  stage_en_t en;
  pt_t       a, a_next;
  dec_t      d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_radius_sq   <= 32'd19825;
      cfg.near_min_sq      <= 32'd19825;
      cfg.near_max_sq      <= 32'd65536;
      cfg.far_min_sq       <= 32'd65536;
      cfg.far_max_sq       <= 32'd5308416;
      cfg.ground_floor     <= 32'sd7864;
      cfg.max_height       <= 32'sd98304;
      cfg.mode_flags       <= 4'hF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SELF_RADIUS_SQ:   cfg.self_radius_sq   <= cfg_data;
        REG_NEAR_MIN_SQ:      cfg.near_min_sq      <= cfg_data;
        REG_NEAR_MAX_SQ:      cfg.near_max_sq      <= cfg_data;
        REG_FAR_MIN_SQ:       cfg.far_min_sq       <= cfg_data;
        REG_FAR_MAX_SQ:       cfg.far_max_sq       <= cfg_data;
        REG_GROUND_FLOOR:     cfg.ground_floor     <= cfg_data;
        REG_MAX_HEIGHT:       cfg.max_height       <= cfg_data;
        REG_MODE_FLAGS:       cfg.mode_flags       <= cfg_data[3:0];
        default:              ;
      endcase
    end
  end

  // stage handshakes: a stage moves when it is empty or the next one moves
  assign rdy_d    = !vd || emit_ready;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_stall = !rdy_a;
  assign in_take  = in_valid && !in_stall;
  assign en.b     = rdy_b;
  assign en.c     = rdy_c;
  assign en.d     = rdy_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      odom_seen      <= 1'b0;
      ref_height     <= '0;
      cur_height     <= '0;
      rot_zx         <= '0;
      rot_zy         <= '0;
      rot_zz         <= '0;
      world_offset_z <= '0;
    end else if (in_take) begin
      if (in_data.func == FUNC_FRAME) begin
        rot_zx         <= clamp_rot(in_data.rot_zx);
        rot_zy         <= clamp_rot(in_data.rot_zy);
        rot_zz         <= clamp_rot(in_data.rot_zz);
        world_offset_z <= in_data.trans_z;
      end else if (in_data.func == FUNC_ODOM) begin
        cur_height <= in_data.odom_height;
        if (!odom_seen) begin
          ref_height <= in_data.odom_height;
          odom_seen  <= 1'b1;
        end
      end
    end
  end

  // a point missing required odometry never enters the pipeline
  assign odom_ok = !(cfg.mode_flags[MODE_NEED_ODOM] && !odom_seen);

  always_comb begin
    a_next.px          = in_data.px;
    a_next.py          = in_data.py;
    a_next.pz          = in_data.pz;
    a_next.intensity   = in_data.intensity;
    a_next.point_valid = in_data.point_valid;
    a_next.filter_on   = cfg.mode_flags[MODE_FILTER_ON];
    a_next.ground_en   = cfg.mode_flags[MODE_GROUND_EN];
    a_next.rot_zx      = rot_zx;
    a_next.rot_zy      = rot_zy;
    a_next.rot_zz      = rot_zz;
    a_next.woff        = world_offset_z;
    if (cfg.mode_flags[MODE_HEIGHT_CMP] && odom_seen) begin
      a_next.dz = 33'(cur_height) - 33'(ref_height);
    end else begin
      a_next.dz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (rdy_a) va <= in_take && (in_data.func == FUNC_POINT) && odom_ok;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a <= a_next;
    end
  end

  lrhs_arith u_arith (
    .clk (clk),
    .en  (en),
    .a   (a),
    .cfg (cfg),
    .d   (d)
  );

  lrhs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .vd        (vd),
    .d         (d),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // only the near copy of a pass-through pair is not last
  a_first_near: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_run |-> out_data.band == BAND_NEAR)
    else $error("non-last word not on near band");

  // the far copy follows right after the near copy is taken
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_of_run |=>
      out_valid && out_data.last_of_run && out_data.band == BAND_FAR)
    else $error("far copy of pass-through pair missing");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> va && vb && vc && vd)
    else $error("input stalled with a free pipeline slot");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    (rot_zx <= ROT_ONE) && (rot_zx >= -ROT_ONE) &&
    (rot_zy <= ROT_ONE) && (rot_zy >= -ROT_ONE) &&
    (rot_zz <= ROT_ONE) && (rot_zz >= -ROT_ONE))
    else $error("stored rotation row out of range");

endmodule
